@@ src/circular_deque_defines.svh @@
// ----------------------------------------------------------------------------
// circular_deque_defines.svh
// Assertion macros for the circular deque RTL.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_DEQUE_DEFINES_SVH
`define CIRCULAR_DEQUE_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent.
`define CD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("circular_deque: next-cycle check failed");

// The consequent must hold in the same cycle as the antecedent.
`define CD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("circular_deque: same-cycle check failed");

`endif

@@ src/cd_pkg.sv @@
// ----------------------------------------------------------------------------
// cd_pkg
// Command and status codes and the controller-to-datapath command bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cd_pkg;

    localparam int CMD_W    = 2;
    localparam int DATA_W   = 8;
    localparam int STATUS_W = 2;

    localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_POP_REAR   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic load;   // capture the incoming command beat
        logic exec;   // carry out the captured command
    } t_dp_cmd;

endpackage

`default_nettype wire

@@ src/cd_ctrl.sv @@
// ----------------------------------------------------------------------------
// cd_ctrl
// Sequencer: accepts a command, runs it in its execution state, then strobes the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cd_ctrl import cd_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    output logic         o_busy,
    output logic         o_valid,
    output t_dp_cmd      o_dp_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    // A new command may enter while the previous result is on the outputs.
    assign o_busy  = (r_state == S_EXEC);
    assign o_valid = (r_state == S_OUT);
    assign accept  = i_start && !o_busy;

    assign o_dp_cmd.load = accept;
    assign o_dp_cmd.exec = (r_state == S_EXEC);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                n_state = accept ? S_EXEC : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

@@ src/cd_datapath.sv @@
// ----------------------------------------------------------------------------
// cd_datapath
// Ring store, front and rear pointers, vacancy flag and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cd_datapath import cd_pkg::*; #(
    parameter int DEPTH = 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_dp_cmd             i_dp_cmd,
    input  wire logic [CMD_W-1:0]    i_command,
    input  wire logic [DATA_W-1:0]   i_data_in,
    output logic [DATA_W-1:0]        o_data_out,
    output logic [STATUS_W-1:0]      o_status,
    output logic                     o_now_empty,
    output logic                     o_now_full
);

    localparam int               PTR_W = $clog2(DEPTH);
    localparam logic [PTR_W-1:0] LAST  = PTR_W'(DEPTH - 1);

    logic [DATA_W-1:0] r_mem [DEPTH];

    logic [CMD_W-1:0]  r_cmd;
    logic [DATA_W-1:0] r_data;
    logic [PTR_W-1:0]  r_head, n_head;
    logic [PTR_W-1:0]  r_tail, n_tail;
    logic              r_vacant, n_vacant;

    logic [DATA_W-1:0]   r_rd_data;
    logic                r_pop_ok;
    logic [STATUS_W-1:0] r_status;
    logic                r_empty;
    logic                r_full;

    logic                is_push;
    logic                full_now;
    logic                we;
    logic [PTR_W-1:0]    wr_addr;
    logic [PTR_W-1:0]    rd_addr;
    logic                pop_ok;
    logic [STATUS_W-1:0] status;
    logic [PTR_W-1:0]    head_next, head_prev, tail_next, tail_prev, n_tail_next;

    assign head_next   = (r_head == LAST) ? '0 : r_head + 1'b1;
    assign head_prev   = (r_head == '0) ? LAST : r_head - 1'b1;
    assign tail_next   = (r_tail == LAST) ? '0 : r_tail + 1'b1;
    assign tail_prev   = (r_tail == '0) ? LAST : r_tail - 1'b1;
    assign n_tail_next = (n_tail == LAST) ? '0 : n_tail + 1'b1;

    assign is_push  = (r_cmd == CMD_PUSH_REAR) || (r_cmd == CMD_PUSH_FRONT);
    assign full_now = !r_vacant && (r_head == tail_next);

    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_vacant = r_vacant;
        we       = 1'b0;
        wr_addr  = '0;
        pop_ok   = 1'b0;
        status   = ST_DONE;
        rd_addr  = (r_cmd == CMD_POP_FRONT) ? r_head : r_tail;
        if (is_push) begin
            if (full_now) begin
                status = ST_FULL;
            end else if (r_vacant) begin
                // The first item always lands in entry zero.
                n_head   = '0;
                n_tail   = '0;
                n_vacant = 1'b0;
                we       = 1'b1;
                wr_addr  = '0;
            end else if (r_cmd == CMD_PUSH_REAR) begin
                n_tail  = tail_next;
                we      = 1'b1;
                wr_addr = tail_next;
            end else begin
                n_head  = head_prev;
                we      = 1'b1;
                wr_addr = head_prev;
            end
        end else begin
            if (r_vacant) begin
                status = ST_EMPTY;
            end else begin
                pop_ok = 1'b1;
                if (r_head == r_tail) begin
                    n_head   = '0;
                    n_tail   = '0;
                    n_vacant = 1'b1;
                end else if (r_cmd == CMD_POP_FRONT) begin
                    n_head = head_next;
                end else begin
                    n_tail = tail_prev;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.exec && we) begin
            r_mem[wr_addr] <= r_data;
        end
        if (i_dp_cmd.exec) begin
            r_rd_data <= r_mem[rd_addr];
            r_pop_ok  <= pop_ok;
            r_status  <= status;
            r_empty   <= n_vacant;
            r_full    <= !n_vacant && (n_head == n_tail_next);
        end
        if (i_dp_cmd.load) begin
            r_cmd  <= i_command;
            r_data <= i_data_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_tail   <= '0;
            r_vacant <= 1'b1;
        end else if (i_dp_cmd.exec) begin
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_vacant <= n_vacant;
        end
    end

    assign o_data_out  = r_pop_ok ? r_rd_data : '0;
    assign o_status    = r_status;
    assign o_now_empty = r_empty;
    assign o_now_full  = r_full;

endmodule

`default_nettype wire

@@ src/circular_deque.sv @@
// Circular deque of bytes with DEPTH entries. A command beat is taken at a
// rising edge where start is high and busy is low. The next cycle is its
// execution cycle: the pointers move, and the ring store is written (push)
// or read (pop). Its result follows on the o_ ports with a one-cycle o_valid
// strobe, and is taken at the rising edge that ends that strobe.
// The receiver cannot stall. Busy is high only during the execution cycle,
// because the captured command is being carried out then. A new command may
// be accepted in the cycle the previous result is shown, but not while
// a command is executing. No clearing pass follows reset; the deque comes
// out of reset empty.
// ----------------------------------------------------------------------------
// circular_deque
// Top level: controller and datapath of the double-ended byte queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "circular_deque_defines.svh"

module circular_deque import cd_pkg::*; #(
    parameter int DEPTH = 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [CMD_W-1:0]    i_command,
    input  wire logic [DATA_W-1:0]   i_data_in,
    output logic                     o_valid,
    output logic [DATA_W-1:0]        o_data_out,
    output logic [STATUS_W-1:0]      o_status,
    output logic                     o_now_empty,
    output logic                     o_now_full
);

    t_dp_cmd dp_cmd;

    cd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .o_busy   (busy),
        .o_valid  (o_valid),
        .o_dp_cmd (dp_cmd)
    );

    cd_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dp_cmd    (dp_cmd),
        .i_command   (i_command),
        .i_data_in   (i_data_in),
        .o_data_out  (o_data_out),
        .o_status    (o_status),
        .o_now_empty (o_now_empty),
        .o_now_full  (o_now_full)
    );

    // Every accepted beat is executed next cycle and reported the cycle after.
    `CD_ASSERT_NEXT(a_accept_exec, i_clk, i_rst_n, start && !busy, busy)
    `CD_ASSERT_NEXT(a_exec_result, i_clk, i_rst_n, busy, o_valid && !busy)
    // Refusals leave the deque at the limit that caused them.
    `CD_ASSERT_SAME(a_full_refusal, i_clk, i_rst_n,
        o_valid && (o_status == ST_FULL), o_now_full && !o_now_empty)
    `CD_ASSERT_SAME(a_empty_refusal, i_clk, i_rst_n,
        o_valid && (o_status == ST_EMPTY), o_now_empty && (o_data_out == '0))

endmodule

`default_nettype wire

@@ test/circular_deque_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_deque_tb
// Self-checking bench for the circular byte deque. Command beats come from a
// queue filled up front. A directed opening covers the empty and full edges.
// Random fill, drain and mixed bursts follow, under three sender idle profiles. A
// cycle-free predictor works out the expected result for each accepted beat,
// and the monitor compares every strobed result with the oldest expectation.
// ----------------------------------------------------------------------------

module circular_deque_tb;
    import cd_pkg::*;

    localparam int DEPTH = 8;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int RANDOM_PER_PHASE = 275;

    typedef struct {
        logic [CMD_W-1:0]  command;
        logic [DATA_W-1:0] data;
        int unsigned       phase;
        bit                drain_first;
    } t_deque_cmd;

    typedef struct packed {
        logic [DATA_W-1:0]   data_out;
        logic [STATUS_W-1:0] status;
        logic                now_empty;
        logic                now_full;
    } t_deque_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic [CMD_W-1:0]    i_command = '0;
    logic [DATA_W-1:0]   i_data_in = '0;
    logic                busy;
    logic                o_valid;
    logic [DATA_W-1:0]   o_data_out;
    logic [STATUS_W-1:0] o_status;
    logic                o_now_empty;
    logic                o_now_full;

    circular_deque #(.DEPTH(DEPTH)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_command  (i_command),
        .i_data_in  (i_data_in),
        .o_valid    (o_valid),
        .o_data_out (o_data_out),
        .o_status   (o_status),
        .o_now_empty(o_now_empty),
        .o_now_full (o_now_full)
    );

    t_deque_cmd    pending_cmds[$];
    t_deque_result expected_results[$];
    int unsigned   idle_pct[3] = '{33, 88, 0};

    int error_count = 0;
    int results_checked = 0;
    int pops_with_data = 0;
    int full_refusals = 0;
    int empty_refusals = 0;

    // Predictor state: ring contents, front and rear pointers, empty flag.
    logic [DATA_W-1:0] ring_store[DEPTH];
    logic [PTR_W-1:0]  front_ptr = '0;
    logic [PTR_W-1:0]  rear_ptr = '0;
    logic              ring_vacant = 1'b1;

    function automatic logic [PTR_W-1:0] ring_fwd(logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] ring_back(logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_W'(DEPTH - 1) : p - 1'b1;
    endfunction

    function automatic logic ring_full();
        return !ring_vacant && front_ptr == ring_fwd(rear_ptr);
    endfunction

    function automatic t_deque_result apply_deque_cmd(logic [CMD_W-1:0] cmd,
                                                      logic [DATA_W-1:0] byte_in);
        t_deque_result res;
        res = '0;
        res.status = ST_DONE;
        if (cmd == CMD_PUSH_REAR || cmd == CMD_PUSH_FRONT) begin
            if (ring_full()) begin
                res.status = ST_FULL;
            end else if (ring_vacant) begin
                // The first item always lands in entry zero.
                front_ptr = '0;
                rear_ptr = '0;
                ring_vacant = 1'b0;
                ring_store[0] = byte_in;
            end else if (cmd == CMD_PUSH_REAR) begin
                rear_ptr = ring_fwd(rear_ptr);
                ring_store[rear_ptr] = byte_in;
            end else begin
                front_ptr = ring_back(front_ptr);
                ring_store[front_ptr] = byte_in;
            end
        end else begin
            if (ring_vacant) begin
                res.status = ST_EMPTY;
            end else begin
                res.data_out = (cmd == CMD_POP_FRONT) ? ring_store[front_ptr]
                                                      : ring_store[rear_ptr];
                if (front_ptr == rear_ptr) begin
                    ring_vacant = 1'b1;
                    front_ptr = '0;
                    rear_ptr = '0;
                end else if (cmd == CMD_POP_FRONT) begin
                    front_ptr = ring_fwd(front_ptr);
                end else begin
                    rear_ptr = ring_back(rear_ptr);
                end
            end
        end
        res.now_empty = ring_vacant;
        res.now_full = ring_full();
        return res;
    endfunction

    task automatic queue_cmd(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] data,
                             int unsigned phase, bit drain_first);
        t_deque_cmd c;
        c.command = cmd;
        c.data = data;
        c.phase = phase;
        c.drain_first = drain_first;
        pending_cmds.push_back(c);
    endtask

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Driver: one beat is offered at a time and held until accepted.
    always @(posedge i_clk) begin
        t_deque_cmd        c;
        logic              start_n;
        logic [CMD_W-1:0]  cmd_n;
        logic [DATA_W-1:0] data_n;
        bit                held;
        start_n = start;
        cmd_n = i_command;
        data_n = i_data_in;
        if (!i_rst_n) begin
            start_n = 1'b0;
        end else begin
            held = start;
            if (start && !busy) begin
                expected_results.push_back(apply_deque_cmd(i_command, i_data_in));
                held = 1'b0;
                start_n = 1'b0;
            end
            if (!held && pending_cmds.size() != 0) begin
                // A drain-first beat waits until every earlier result is back.
                if (!(pending_cmds[0].drain_first && expected_results.size() != 0) &&
                    $urandom_range(0, 99) >= idle_pct[pending_cmds[0].phase]) begin
                    c = pending_cmds.pop_front();
                    start_n = 1'b1;
                    cmd_n = c.command;
                    data_n = c.data;
                end
            end
        end
        start <= start_n;
        i_command <= cmd_n;
        i_data_in <= data_n;
    end

    // Monitor: every strobed result is checked against the oldest expectation.
    always @(posedge i_clk) begin
        t_deque_result want;
        if (i_rst_n && o_valid) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result: data_out %0h status %0d empty %0b full %0b",
                         $time, o_data_out, o_status, o_now_empty, o_now_full);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                if (want.status == ST_FULL) full_refusals++;
                else if (want.status == ST_EMPTY) empty_refusals++;
                else if (!want.now_empty || want.data_out != 0 || o_data_out != 0)
                    pops_with_data += (want.data_out != 0) ? 1 : 0;
                if (o_data_out !== want.data_out) begin
                    $display("%0t: data_out mismatch: expected %0h, actual %0h",
                             $time, want.data_out, o_data_out);
                    error_count++;
                end
                if (o_status !== want.status) begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, want.status, o_status);
                    error_count++;
                end
                if (o_now_empty !== want.now_empty) begin
                    $display("%0t: now_empty mismatch: expected %0b, actual %0b",
                             $time, want.now_empty, o_now_empty);
                    error_count++;
                end
                if (o_now_full !== want.now_full) begin
                    $display("%0t: now_full mismatch: expected %0b, actual %0b",
                             $time, want.now_full, o_now_full);
                    error_count++;
                end
            end
        end
    end

    initial begin
        int          made;
        int          burst_len;
        int          mode;
        int          push_pct;
        bit          first;
        logic [CMD_W-1:0] cmd;

        // Directed opening: refused pops, single-item round trips, a full
        // ring built from both ends, refused pushes, a mixed drain and one more refused pop.
        queue_cmd(CMD_POP_FRONT, 8'hFF, 0, 1'b0);
        queue_cmd(CMD_POP_REAR, 8'h00, 0, 1'b0);
        queue_cmd(CMD_PUSH_REAR, 8'h00, 0, 1'b0);
        queue_cmd(CMD_POP_REAR, 8'h00, 0, 1'b0);
        queue_cmd(CMD_PUSH_FRONT, 8'hFF, 0, 1'b0);
        queue_cmd(CMD_POP_FRONT, 8'h00, 0, 1'b0);
        for (int k = 0; k < DEPTH / 2; k++) begin
            queue_cmd(CMD_PUSH_REAR, 8'h55 ^ DATA_W'(k), 0, 1'b0);
            queue_cmd(CMD_PUSH_FRONT, 8'hAA ^ DATA_W'(k << 4), 0, 1'b0);
        end
        queue_cmd(CMD_PUSH_REAR, 8'hFF, 0, 1'b0);
        queue_cmd(CMD_PUSH_FRONT, 8'h01, 0, 1'b0);
        for (int k = 0; k < DEPTH / 2; k++) begin
            queue_cmd(CMD_POP_FRONT, 8'h00, 0, 1'b0);
            queue_cmd(CMD_POP_REAR, 8'h00, 0, 1'b0);
        end
        queue_cmd(CMD_POP_FRONT, 8'h80, 0, 1'b0);

        // Random part: fill bursts, drain bursts and uniform noise, so the
        // ring swings between empty and full many times.
        for (int ph = 0; ph < 3; ph++) begin
            made = 0;
            first = 1'b1;
            while (made < RANDOM_PER_PHASE) begin
                burst_len = $urandom_range(3, 20);
                mode = $urandom_range(0, 9);
                push_pct = (mode < 4) ? 80 : (mode < 8) ? 20 : 50;
                for (int k = 0; k < burst_len; k++) begin
                    if ($urandom_range(0, 99) < push_pct)
                        cmd = $urandom_range(0, 1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
                    else
                        cmd = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_REAR;
                    queue_cmd(cmd, DATA_W'($urandom_range(0, 255)), ph, first);
                    first = 1'b0;
                    made++;
                end
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || start || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Checked %0d results: %0d pops with nonzero data, %0d full refusals, %0d empty refusals.",
                 results_checked, pops_with_data, full_refusals, empty_refusals);
        $display("Sender ran with heavy, light and no idling; the ring hit both ends many times.");
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("Timeout with %0d results still outstanding.", expected_results.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
